FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/mhbi_pkg.sv
// Package: constants, widths and types of the hash bucket index unit.
package mhbi_pkg;

    localparam int KEY_W    = 64;
    localparam int CNT_W    = 4;
    localparam int HASH_W   = 32;
    localparam int IDX_W    = 16;
    localparam int LOG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int OPS      = 4;
    localparam int STEP_W   = 2;
    localparam int NSTEP_W  = 3;

    localparam logic [HASH_W-1:0] SEED_HASH = 32'h811c_9dc5;
    localparam logic [19:0]       MUL_CONST = 20'had3e7;
    localparam logic [LOG_W-1:0]  MAX_LOG   = 5'd16;
    localparam logic [CNT_W-1:0]  FULL_CNT  = 4'd8;
    localparam logic [LOG_W-1:0]  RST_LOG_SEG = 5'd10;
    localparam logic [LOG_W-1:0]  RST_LOG_BKT = 5'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_SEG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_BKT = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MIX  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Clamp a log-size register to the largest supported value
    function automatic logic [LOG_W-1:0] clamp_log(input logic [LOG_W-1:0] v);
        clamp_log = (v > MAX_LOG) ? MAX_LOG : v;
    endfunction

endpackage

FILE: design/mhbi_key_if.sv
// Interface: key word channel.
interface mhbi_key_if;
    import mhbi_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    key_word;
    logic [CNT_W-1:0]    byte_count;
    logic                last_word;

    modport source (output valid, output key_word, output byte_count, output last_word,
                    input ready);
    modport sink   (input valid, input key_word, input byte_count, input last_word,
                    output ready);
endinterface

FILE: design/mhbi_res_if.sv
// Interface: hash result channel.
interface mhbi_res_if;
    import mhbi_pkg::*;

    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   hash_value;
    logic [IDX_W-1:0]    segment_index;
    logic [IDX_W-1:0]    bucket_index;
    logic [HASH_W-1:0]   table_index;
    logic                framing_error;

    modport source (output valid, output hash_value, output segment_index,
                    output bucket_index, output table_index, output framing_error,
                    input ready);
    modport sink   (input valid, input hash_value, input segment_index,
                    input bucket_index, input table_index, input framing_error,
                    output ready);
endinterface

FILE: design/meiyan_hash_bucket_index_unit.sv
// Top level: hash of a multi-word key and its segment / bucket / table index.
//
// Usage:
//   key    - sink channel; one little-endian 64-bit key word per transfer with
//            its byte count and a last-word flag.
//   result - source channel; one transfer per key, after its last word.
//   cfg_*  - write port for log_segments (index 0) and log_buckets_per_segment
//            (index 1); write only while the unit is idle.
// Timing:
//   A word is folded by one shared 32x20 constant multiplier, one mix per
//   cycle: a full word needs one mix, a short last word zero to four.
//   key.ready is high only in the idle state, so no new word is taken
//   until the mixes of the current word are done.
//   A last word then passes the finishing state, which loads the result
//   into the output register.
//   The result sits in an output register; the next key word is taken while it
//   waits. If the receiver stalls, a following key stops in its finishing
//   state until the register is free.
// Reset: running hash back to its seed, error flag clear, output empty,
//   log_segments = 10, log_buckets_per_segment = 0.
`include "assert_macros.svh"

module meiyan_hash_bucket_index_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    mhbi_key_if.sink                           key,
    mhbi_res_if.source                         result,
    input  logic                               cfg_we,
    input  logic [mhbi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mhbi_pkg::LOG_W-1:0]         cfg_data
);
    import mhbi_pkg::*;

    state_t                 state_reg, state_next;
    logic [HASH_W-1:0]      h_reg, h_next;
    logic                   err_reg, err_next;
    logic                   last_reg, last_next;
    logic [HASH_W-1:0]      ops_reg [OPS], ops_next [OPS];
    logic [NSTEP_W-1:0]     steps_reg, steps_next;
    logic [STEP_W-1:0]      step_idx_reg, step_idx_next;
    logic [LOG_W-1:0]       log_seg_reg, log_bkt_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]      out_hash_reg;
    logic [IDX_W-1:0]       out_seg_reg, out_bkt_reg;
    logic [HASH_W-1:0]      out_tbl_reg;
    logic                   out_err_reg;

    logic                   accept;
    logic                   fin_go;
    logic [CNT_W-1:0]       cnt_c;
    logic [HASH_W-1:0]      cand [OPS];
    logic [OPS-1:0]         cand_en;
    logic [HASH_W-1:0]      lo_half, rot_lo;
    logic [7:0]             tail_byte;
    logic [15:0]            tail_part;
    logic [HASH_W-1:0]      mix_in, mix_prod;
    logic [HASH_W-1:0]      fin_hash, fin_shift;
    logic [LOG_W-1:0]       ls_c, lb_c;
    logic [HASH_W-1:0]      seg_mask, bkt_mask;
    logic [IDX_W-1:0]       fin_seg, fin_bkt;
    logic [HASH_W-1:0]      fin_tbl;

    assign key.ready = (state_reg == ST_IDLE);
    assign accept    = key.valid && key.ready;
    assign fin_go    = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    // Byte count above eight counts as eight
    assign cnt_c = (key.byte_count > FULL_CNT) ? FULL_CNT : key.byte_count;

    // Rotated low half for a full word; candidate mix operands for a short tail, in folding order
    assign lo_half = key.key_word[31:0];
    assign rot_lo  = {lo_half[26:0], lo_half[31:27]};

    always_comb
    begin
        unique case ({cnt_c[2], cnt_c[1]})
            2'b00:   tail_byte = key.key_word[7:0];
            2'b01:   tail_byte = key.key_word[23:16];
            2'b10:   tail_byte = key.key_word[39:32];
            default: tail_byte = key.key_word[55:48];
        endcase
        tail_part = cnt_c[2] ? key.key_word[47:32] : key.key_word[15:0];
    end

    always_comb
    begin
        cand[0] = {16'b0, key.key_word[15:0]};
        cand[1] = {16'b0, key.key_word[31:16]};
        cand[2] = {16'b0, tail_part};
        cand[3] = {{24{tail_byte[7]}}, tail_byte};
        cand_en = {cnt_c[0], cnt_c[1], cnt_c[2], cnt_c[2]};
    end

    // Shared mixing unit: xor then constant multiply, registered into h_reg
    assign mix_in   = h_reg ^ ops_reg[step_idx_reg];
    assign mix_prod = HASH_W'(mix_in * {12'b0, MUL_CONST});

    // Final mix and index extraction
    always_comb
    begin
        fin_shift = h_reg >> 16;
        fin_hash  = h_reg ^ fin_shift;
        ls_c      = clamp_log(log_seg_reg);
        lb_c      = clamp_log(log_bkt_reg);
        seg_mask  = ~({HASH_W{1'b1}} << ls_c);
        bkt_mask  = ~({HASH_W{1'b1}} << lb_c);
        fin_seg   = fin_hash[IDX_W-1:0] & seg_mask[IDX_W-1:0];
        fin_bkt   = IDX_W'((fin_hash >> ls_c) & bkt_mask);
        fin_tbl   = ({16'b0, fin_seg} << lb_c) | {16'b0, fin_bkt};
    end

    // Sequencer
    always_comb
    begin
        logic [NSTEP_W-1:0] n;
        state_next     = state_reg;
        h_next         = h_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        steps_next     = steps_reg;
        step_idx_next  = step_idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        n              = '0;
        for (int i = 0; i < OPS; i++)
        begin
            ops_next[i] = ops_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next     = key.last_word;
                    step_idx_next = '0;
                    if (cnt_c == FULL_CNT)
                    begin
                        ops_next[0] = rot_lo ^ key.key_word[63:32];
                        n           = NSTEP_W'(1);
                    end
                    else if (key.last_word)
                    begin
                        // Compact the enabled tail parts into the operand queue
                        for (int i = 0; i < OPS; i++)
                        begin
                            if (cand_en[i])
                            begin
                                ops_next[n[STEP_W-1:0]] = cand[i];
                                n = n + NSTEP_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                    steps_next = n;
                    if (n != '0)
                        state_next = ST_MIX;
                    else if (key.last_word)
                        state_next = ST_FIN;
                end
            end
            ST_MIX:
            begin
                h_next        = mix_prod;
                step_idx_next = step_idx_reg + STEP_W'(1);
                if ({1'b0, step_idx_reg} + NSTEP_W'(1) == steps_reg)
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    h_next         = SEED_HASH;
                    err_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= SEED_HASH;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            log_seg_reg   <= RST_LOG_SEG;
            log_bkt_reg   <= RST_LOG_BKT;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOG_SEG: log_seg_reg <= cfg_data;
                    CFG_LOG_BKT: log_bkt_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // Operand queue and step counters
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        steps_reg    <= steps_next;
        step_idx_reg <= step_idx_next;
        for (int i = 0; i < OPS; i++)
        begin
            ops_reg[i] <= ops_next[i];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_hash_reg <= fin_hash;
            out_seg_reg  <= fin_seg;
            out_bkt_reg  <= fin_bkt;
            out_tbl_reg  <= fin_tbl;
            out_err_reg  <= err_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.hash_value    = out_hash_reg;
    assign result.segment_index = out_seg_reg;
    assign result.bucket_index  = out_bkt_reg;
    assign result.table_index   = out_tbl_reg;
    assign result.framing_error = out_err_reg;

    // Checks
    `ASSERT_CLK(a_mix_in_range,
        (state_reg == ST_MIX) |-> (steps_reg != '0 && {1'b0, step_idx_reg} < steps_reg),
        "mix step beyond queued operands")
    `ASSERT_CLK(a_fin_restarts,
        fin_go |=> (out_valid_reg && h_reg == SEED_HASH && !err_reg),
        "key finish did not restart hash")
    `ASSERT_CLK(a_tbl_width,
        out_valid_reg |-> ((out_tbl_reg >> ({1'b0, clamp_log(log_seg_reg)}
            + {1'b0, clamp_log(log_bkt_reg)})) == '0),
        "table index wider than configured")

endmodule
